@@ src/hferf_pkg.sv @@
// Shared types, widths and fixed-point constants for the half-float erf pipeline.
// No dependencies; every other file but hferf_check imports this package.
package hferf_pkg;

  // fraction bits of the internal unsigned fixed-point format
  localparam int FRAC_BITS = 16;

  localparam int A_W    = FRAC_BITS + 3;  // |x| clamped at 4
  localparam int C_W    = FRAC_BITS + 1;  // coefficients below 2
  localparam int U_W    = FRAC_BITS + 3;  // a*a clamped at 6
  localparam int U2_W   = FRAC_BITS + 6;  // u*u up to 36
  localparam int NUM_W  = FRAC_BITS + 2;
  localparam int DEN_W  = FRAC_BITS + 5;
  localparam int DIV_QW = FRAC_BITS + 2;  // quotient bits, one per stage
  localparam int DIV_DW = DEN_W;
  localparam int DIV_NW = 2 * FRAC_BITS + 3;
  localparam int DIV_CW = DIV_DW + DIV_QW;
  localparam int T_W    = FRAC_BITS + 1;  // t <= 1
  localparam int E_W    = DIV_QW;
  localparam int PS_W   = FRAC_BITS + 2;  // positive polynomial sum
  localparam int NS_W   = FRAC_BITS + 1;  // negative polynomial sum
  localparam int PR_W   = FRAC_BITS + 4;
  localparam int R_W    = FRAC_BITS + 1;  // result magnitude <= 1
  localparam int K_W    = $clog2(R_W);

  typedef logic [C_W-1:0] coef_t;

  localparam coef_t ONE_Q    = coef_t'(64'd1 << FRAC_BITS);
  localparam coef_t QC_3280  = coef_t'(((64'd3280  << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam coef_t QC_2505  = coef_t'(((64'd2505  << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam coef_t QC_2881  = coef_t'(((64'd2881  << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam coef_t QC_14102 = coef_t'(((64'd14102 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam coef_t QC_14230 = coef_t'(((64'd14230 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam coef_t QC_10547 = coef_t'(((64'd10547 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam coef_t QC_13300 = coef_t'(((64'd13300 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam coef_t QC_3900  = coef_t'(((64'd3900  << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam coef_t QC_288   = coef_t'(((64'd288   << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam coef_t QC_13380 = coef_t'(((64'd13380 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam coef_t QC_8480  = coef_t'(((64'd8480  << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam coef_t QC_4670  = coef_t'(((64'd4670  << FRAC_BITS) + 64'd5000) / 64'd10000);

  // binary16 codes
  localparam logic [15:0] HALF_ONE  = 16'h3C00;
  localparam logic [15:0] HALF_SIGN = 16'h8000;
  localparam logic [4:0]  EXP_BIG   = 5'd17;  // |x| >= 4

  // per-item sideband that travels with the data
  typedef struct packed {
    logic vld;
    logic last;
    logic sbit;
    logic neg;
    logic big;
  } side_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [DIV_NW-1:0] rem;
    logic [DIV_DW-1:0] den;
    logic [DIV_QW-1:0] quo;
  } div_lane_t;

endpackage

@@ src/hferf_front.sv @@
// Front end: binary16 decode, |x| to fixed point, and both divider operands.
// Depends on hferf_pkg.
module hferf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [15:0]                x_bits,
  input  logic                       last_in,
  output hferf_pkg::side_t           side_o,
  output hferf_pkg::div_lane_t       t_o,
  output hferf_pkg::div_lane_t       e_o
);
  import hferf_pkg::*;

  localparam logic [41:0] A_MAX = 42'(4) << FRAC_BITS;
  localparam logic [U_W-1:0] U_MAX = U_W'(6) << FRAC_BITS;

  side_t s1_side_r, s2_side_r, s3_side_r, s4_side_r, s5_side_r, s6_side_r;
  logic [A_W-1:0]     s1_a_r;
  logic [FRAC_BITS:0] s2_k1_r;
  logic [FRAC_BITS+4:0] s2_uf_r;
  logic [FRAC_BITS+1:0] s3_d_r, s4_d_r, s5_d_r;
  logic [U_W-1:0]     s3_u_r;
  logic [U2_W-1:0]    s4_u2_r;
  logic [FRAC_BITS+1:0] s4_m3900_r, s5_m3900_r;
  logic [FRAC_BITS+2:0] s4_m8480_r, s5_m8480_r;
  logic [FRAC_BITS:0]   s5_m288_r;
  logic [FRAC_BITS+4:0] s5_m4670_r;
  div_lane_t t_r, e_r;

  // stage 1: decode and align the magnitude
  side_t          s1_side_nxt;
  logic [A_W-1:0] s1_a_nxt;
  always_comb begin
    logic [4:0]  ex;
    logic [4:0]  e1;
    logic [10:0] m11;
    logic [41:0] wide;
    ex   = x_bits[14:10];
    e1   = (ex == 5'd0) ? 5'd1 : ex;
    m11  = {ex != 5'd0, x_bits[9:0]};
    wide = (42'(m11) << (e1 - 5'd1)) >> (24 - FRAC_BITS);
    s1_a_nxt = (wide > A_MAX) ? A_W'(A_MAX) : A_W'(wide);
    s1_side_nxt.vld  = in_vld;
    s1_side_nxt.last = last_in;
    s1_side_nxt.sbit = x_bits[15];
    s1_side_nxt.neg  = x_bits[15] && (x_bits[14:0] != 15'd0);
    s1_side_nxt.big  = (ex >= EXP_BIG);
  end

  // stage 2: 0.328a and a*a
  logic [A_W+C_W-1:0] p_k1;
  logic [2*A_W-1:0]   p_aa;
  assign p_k1 = (A_W+C_W)'(s1_a_r) * (A_W+C_W)'(QC_3280);
  assign p_aa = (2*A_W)'(s1_a_r) * (2*A_W)'(s1_a_r);

  // stage 3: divisor of t and clamp of u
  logic [FRAC_BITS+1:0] s3_d_nxt;
  logic [U_W-1:0]       s3_u_nxt;
  assign s3_d_nxt = (FRAC_BITS+2)'(ONE_Q) + (FRAC_BITS+2)'(s2_k1_r);
  assign s3_u_nxt = (s2_uf_r > (FRAC_BITS+5)'(U_MAX)) ? U_MAX : U_W'(s2_uf_r);

  // stage 4: u squared and the linear terms
  logic [2*U_W-1:0]   p_uu;
  logic [C_W+U_W-1:0] p_3900, p_8480;
  assign p_uu   = (2*U_W)'(s3_u_r) * (2*U_W)'(s3_u_r);
  assign p_3900 = (C_W+U_W)'(s3_u_r) * (C_W+U_W)'(QC_3900);
  assign p_8480 = (C_W+U_W)'(s3_u_r) * (C_W+U_W)'(QC_8480);

  // stage 5: square terms
  logic [C_W+U2_W-1:0] p_288, p_4670;
  assign p_288  = (C_W+U2_W)'(s4_u2_r) * (C_W+U2_W)'(QC_288);
  assign p_4670 = (C_W+U2_W)'(s4_u2_r) * (C_W+U2_W)'(QC_4670);

  // stage 6: numerator, denominator and the rounded dividends
  div_lane_t t_nxt, e_nxt;
  always_comb begin
    logic [NUM_W-1:0] npos;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    npos = NUM_W'(QC_13300) + NUM_W'(s5_m288_r);
    num  = (npos > s5_m3900_r) ? (npos - s5_m3900_r) : '0;
    den  = DEN_W'(QC_13380) + DEN_W'(s5_m8480_r) + DEN_W'(s5_m4670_r);
    e_nxt.rem = (DIV_NW'(num) << FRAC_BITS) + DIV_NW'(den >> 1);
    e_nxt.den = den;
    e_nxt.quo = '0;
    t_nxt.rem = (DIV_NW'(ONE_Q) << FRAC_BITS) + DIV_NW'(s5_d_r >> 1);
    t_nxt.den = DIV_DW'(s5_d_r);
    t_nxt.quo = '0;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.vld <= 1'b0;
      s2_side_r.vld <= 1'b0;
      s3_side_r.vld <= 1'b0;
      s4_side_r.vld <= 1'b0;
      s5_side_r.vld <= 1'b0;
      s6_side_r.vld <= 1'b0;
    end else if (en) begin
      s1_side_r.vld <= s1_side_nxt.vld;
      s2_side_r.vld <= s1_side_r.vld;
      s3_side_r.vld <= s2_side_r.vld;
      s4_side_r.vld <= s3_side_r.vld;
      s5_side_r.vld <= s4_side_r.vld;
      s6_side_r.vld <= s5_side_r.vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      {s1_side_r.last, s1_side_r.sbit, s1_side_r.neg, s1_side_r.big} <=
        {s1_side_nxt.last, s1_side_nxt.sbit, s1_side_nxt.neg, s1_side_nxt.big};
      {s2_side_r.last, s2_side_r.sbit, s2_side_r.neg, s2_side_r.big} <=
        {s1_side_r.last, s1_side_r.sbit, s1_side_r.neg, s1_side_r.big};
      {s3_side_r.last, s3_side_r.sbit, s3_side_r.neg, s3_side_r.big} <=
        {s2_side_r.last, s2_side_r.sbit, s2_side_r.neg, s2_side_r.big};
      {s4_side_r.last, s4_side_r.sbit, s4_side_r.neg, s4_side_r.big} <=
        {s3_side_r.last, s3_side_r.sbit, s3_side_r.neg, s3_side_r.big};
      {s5_side_r.last, s5_side_r.sbit, s5_side_r.neg, s5_side_r.big} <=
        {s4_side_r.last, s4_side_r.sbit, s4_side_r.neg, s4_side_r.big};
      {s6_side_r.last, s6_side_r.sbit, s6_side_r.neg, s6_side_r.big} <=
        {s5_side_r.last, s5_side_r.sbit, s5_side_r.neg, s5_side_r.big};
      s1_a_r     <= s1_a_nxt;
      s2_k1_r    <= p_k1[2*FRAC_BITS:FRAC_BITS];
      s2_uf_r    <= p_aa[2*FRAC_BITS+4:FRAC_BITS];
      s3_d_r     <= s3_d_nxt;
      s3_u_r     <= s3_u_nxt;
      s4_d_r     <= s3_d_r;
      s4_u2_r    <= p_uu[2*FRAC_BITS+5:FRAC_BITS];
      s4_m3900_r <= p_3900[2*FRAC_BITS+1:FRAC_BITS];
      s4_m8480_r <= p_8480[2*FRAC_BITS+2:FRAC_BITS];
      s5_d_r     <= s4_d_r;
      s5_m3900_r <= s4_m3900_r;
      s5_m8480_r <= s4_m8480_r;
      s5_m288_r  <= p_288[2*FRAC_BITS:FRAC_BITS];
      s5_m4670_r <= p_4670[2*FRAC_BITS+4:FRAC_BITS];
      t_r        <= t_nxt;
      e_r        <= e_nxt;
    end
  end

  assign side_o = s6_side_r;
  assign t_o    = t_r;
  assign e_o    = e_r;

endmodule

@@ src/hferf_div.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on hferf_pkg.
module hferf_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  hferf_pkg::side_t         side_i,
  input  hferf_pkg::div_lane_t     t_i,
  input  hferf_pkg::div_lane_t     e_i,
  output hferf_pkg::side_t         side_o,
  output logic [hferf_pkg::T_W-1:0] t_q,
  output logic [hferf_pkg::E_W-1:0] e_q
);
  import hferf_pkg::*;

  // one trial subtraction of den shifted to the given quotient bit
  function automatic div_lane_t div_step(div_lane_t l, int bitpos);
    logic [DIV_CW-1:0] dsh;
    logic [DIV_CW-1:0] rx;
    dsh = DIV_CW'(l.den) << bitpos;
    rx  = DIV_CW'(l.rem);
    if (rx >= dsh) begin
      l.rem = DIV_NW'(rx - dsh);
      l.quo = l.quo | (DIV_QW'(1) << bitpos);
    end
    return l;
  endfunction

  side_t     sd_r [DIV_QW];
  div_lane_t tl_r [DIV_QW];
  div_lane_t el_r [DIV_QW];

  for (genvar g = 0; g < DIV_QW; g++) begin : g_stage
    side_t     sd_in;
    div_lane_t tl_in, el_in;
    if (g == 0) begin : g_first
      assign sd_in = side_i;
      assign tl_in = t_i;
      assign el_in = e_i;
    end else begin : g_next
      assign sd_in = sd_r[g-1];
      assign tl_in = tl_r[g-1];
      assign el_in = el_r[g-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[g].vld <= 1'b0;
      end else if (en) begin
        sd_r[g].vld <= sd_in.vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        {sd_r[g].last, sd_r[g].sbit, sd_r[g].neg, sd_r[g].big} <=
          {sd_in.last, sd_in.sbit, sd_in.neg, sd_in.big};
        tl_r[g] <= div_step(tl_in, DIV_QW - 1 - g);
        el_r[g] <= div_step(el_in, DIV_QW - 1 - g);
      end
    end
  end

  assign side_o = sd_r[DIV_QW-1];
  assign t_q    = tl_r[DIV_QW-1].quo[T_W-1:0];
  assign e_q    = el_r[DIV_QW-1].quo;

endmodule

@@ src/hferf_poly.sv @@
// Quintic polynomial in t, product with the exp term, and 1 - product.
// Depends on hferf_pkg.
module hferf_poly (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  hferf_pkg::side_t           side_i,
  input  logic [hferf_pkg::T_W-1:0]  t_i,
  input  logic [hferf_pkg::E_W-1:0]  e_i,
  output hferf_pkg::side_t           side_o,
  output logic [hferf_pkg::R_W-1:0]  r_o
);
  import hferf_pkg::*;

  localparam int TT_W = 2 * T_W;  // t times t or coefficient times t

  side_t sd_r [8];
  logic [T_W-1:0]  t1_r, t2_r, t3_r;        // t delayed
  logic [E_W-1:0]  e1_r, e2_r, e3_r, e4_r, e5_r, e6_r;
  logic [T_W-1:0]  p1_r, p2_r, p3_r, p4_r;  // t^2 .. t^5
  logic [PS_W-1:0] ps1_r, ps2_r, ps3_r, ps4_r, ps5_r;
  logic [NS_W-1:0] ns2_r, ns3_r, ns4_r, ns5_r;
  logic [PS_W-1:0] poly_r;
  logic [PR_W-1:0] prod_r;
  logic [R_W-1:0]  r_r;

  // powers of t, one multiply per stage
  logic [TT_W-1:0] m_t2, m_t3, m_t4, m_t5;
  assign m_t2 = TT_W'(t_i)  * TT_W'(t_i);
  assign m_t3 = TT_W'(p1_r) * TT_W'(t1_r);
  assign m_t4 = TT_W'(p2_r) * TT_W'(t2_r);
  assign m_t5 = TT_W'(p3_r) * TT_W'(t3_r);

  // coefficient terms
  logic [TT_W-1:0] c1, c2, c3, c4, c5;
  assign c1 = TT_W'(t_i)  * TT_W'(QC_2505);
  assign c2 = TT_W'(p1_r) * TT_W'(QC_2881);
  assign c3 = TT_W'(p2_r) * TT_W'(QC_14102);
  assign c4 = TT_W'(p3_r) * TT_W'(QC_14230);
  assign c5 = TT_W'(p4_r) * TT_W'(QC_10547);

  // product with exp(-a*a)
  logic [PS_W+E_W-1:0] m_pe;
  assign m_pe = (PS_W+E_W)'(poly_r) * (PS_W+E_W)'(e6_r);

  // 1 - product, with the sign flip when the product passes one
  logic [R_W-1:0] r_nxt;
  logic           flip;
  always_comb begin
    logic [PR_W-1:0] over;
    flip = prod_r > PR_W'(ONE_Q);
    over = prod_r - PR_W'(ONE_Q);
    if (flip) begin
      r_nxt = (over > PR_W'(ONE_Q)) ? R_W'(ONE_Q) : R_W'(over);
    end else begin
      r_nxt = R_W'(PR_W'(ONE_Q) - prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) sd_r[i].vld <= 1'b0;
    end else if (en) begin
      sd_r[0].vld <= side_i.vld;
      for (int i = 1; i < 8; i++) sd_r[i].vld <= sd_r[i-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {sd_r[0].last, sd_r[0].sbit, sd_r[0].neg, sd_r[0].big} <=
        {side_i.last, side_i.sbit, side_i.neg, side_i.big};
      for (int i = 1; i < 7; i++) begin
        {sd_r[i].last, sd_r[i].sbit, sd_r[i].neg, sd_r[i].big} <=
          {sd_r[i-1].last, sd_r[i-1].sbit, sd_r[i-1].neg, sd_r[i-1].big};
      end
      sd_r[7].last <= sd_r[6].last;
      sd_r[7].sbit <= sd_r[6].sbit;
      sd_r[7].neg  <= sd_r[6].neg ^ flip;
      sd_r[7].big  <= sd_r[6].big;
      // stage 1
      t1_r  <= t_i;
      e1_r  <= e_i;
      p1_r  <= m_t2[2*FRAC_BITS:FRAC_BITS];
      ps1_r <= PS_W'(c1[2*FRAC_BITS:FRAC_BITS]);
      // stage 2
      t2_r  <= t1_r;
      e2_r  <= e1_r;
      p2_r  <= m_t3[2*FRAC_BITS:FRAC_BITS];
      ps2_r <= ps1_r;
      ns2_r <= NS_W'(c2[2*FRAC_BITS:FRAC_BITS]);
      // stage 3
      t3_r  <= t2_r;
      e3_r  <= e2_r;
      p3_r  <= m_t4[2*FRAC_BITS:FRAC_BITS];
      ps3_r <= ps2_r + PS_W'(c3[2*FRAC_BITS:FRAC_BITS]);
      ns3_r <= ns2_r;
      // stage 4
      e4_r  <= e3_r;
      p4_r  <= m_t5[2*FRAC_BITS:FRAC_BITS];
      ps4_r <= ps3_r;
      ns4_r <= ns3_r + NS_W'(c4[2*FRAC_BITS:FRAC_BITS]);
      // stage 5
      e5_r  <= e4_r;
      ps5_r <= ps4_r + PS_W'(c5[2*FRAC_BITS:FRAC_BITS]);
      ns5_r <= ns4_r;
      // stage 6
      e6_r   <= e5_r;
      poly_r <= (ps5_r > PS_W'(ns5_r)) ? (ps5_r - PS_W'(ns5_r)) : '0;
      // stage 7
      prod_r <= m_pe[FRAC_BITS+PR_W-1:FRAC_BITS];
      // stage 8
      r_r    <= r_nxt;
    end
  end

  assign side_o = sd_r[7];
  assign r_o    = r_r;

endmodule

@@ src/hferf_pack.sv @@
// Fixed-point magnitude to binary16: leading-one search, then shift and round.
// Depends on hferf_pkg.
module hferf_pack (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  hferf_pkg::side_t          side_i,
  input  logic [hferf_pkg::R_W-1:0] r_i,
  output hferf_pkg::side_t          side_o,
  output logic [15:0]               y_o
);
  import hferf_pkg::*;

  side_t          k_side_r, y_side_r;
  logic [R_W-1:0] k_m_r;
  logic [K_W-1:0] k_r;
  logic [15:0]    y_r;

  // leading-one position
  logic [K_W-1:0] k_nxt;
  always_comb begin
    k_nxt = '0;
    for (int i = 0; i < R_W; i++) begin
      if (r_i[i]) k_nxt = K_W'(i);
    end
  end

  // normalize, round to nearest even, assemble
  logic [15:0] y_nxt;
  always_comb begin
    int            nshift;
    logic [R_W-1:0] norm;
    logic [11:0]   mant;
    logic          rnd;
    logic [15:0]   mag;
    logic [R_W+11:0] sub;
    nshift = FRAC_BITS - int'(k_r);
    norm = k_m_r << nshift;
    rnd  = norm[FRAC_BITS-11] && ((|norm[FRAC_BITS-12:0]) || norm[FRAC_BITS-10]);
    mant = {1'b0, norm[FRAC_BITS:FRAC_BITS-10]} + 12'(rnd);
    sub  = (R_W+12)'(k_m_r) << (24 - FRAC_BITS);
    if (k_m_r == '0) begin
      mag = 16'd0;
    end else if (nshift >= 15) begin
      mag = sub[15:0];
    end else begin
      mag = ({6'(15 - nshift), 10'd0} + 16'(mant)) - 16'd1024;
    end
    if (k_side_r.big) begin
      y_nxt = k_side_r.sbit ? (HALF_ONE | HALF_SIGN) : HALF_ONE;
    end else begin
      y_nxt = k_side_r.neg ? (mag | HALF_SIGN) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_side_r.vld <= 1'b0;
      y_side_r.vld <= 1'b0;
    end else if (en) begin
      k_side_r.vld <= side_i.vld;
      y_side_r.vld <= k_side_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {k_side_r.last, k_side_r.sbit, k_side_r.neg, k_side_r.big} <=
        {side_i.last, side_i.sbit, side_i.neg, side_i.big};
      {y_side_r.last, y_side_r.sbit, y_side_r.neg, y_side_r.big} <=
        {k_side_r.last, k_side_r.sbit, k_side_r.neg, k_side_r.big};
      k_m_r <= r_i;
      k_r   <= k_nxt;
      y_r   <= y_nxt;
    end
  end

  assign side_o = y_side_r;
  assign y_o    = y_r;

endmodule

@@ src/half_float_erf_approximation.sv @@
// Top level of the half-float erf pipeline: front end, dividers, polynomial, packer.
// Depends on hferf_pkg, hferf_front, hferf_div, hferf_poly, hferf_pack.
//
//  channel | direction | payload (low bit first)      | transfer when
//  in_     | slave     | tdata: x_bits[15:0]; tlast   | in_tvalid && in_tready
//  out_    | master    | tdata: y_bits[15:0]; tlast   | out_tvalid && out_tready
//
// One item per cycle while no result waits or out_tready is high; the pipeline depth
// is set mostly by the two pipelined restoring dividers, one quotient bit a stage.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
// When a result waits and out_tready is low, one enable freezes every stage,
// so in_tready drops in the same cycle and nothing is lost or repeated.
module half_float_erf_approximation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] x_bits
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] y_bits
  output logic        out_tlast
);
  import hferf_pkg::*;

  logic      en;
  side_t     f_side, d_side, p_side, y_side;
  div_lane_t t_lane, e_lane;
  logic [T_W-1:0] t_q;
  logic [E_W-1:0] e_q;
  logic [R_W-1:0] r;
  logic [15:0]    y;

  // global advance: the output slot is free or being drained
  assign en        = !y_side.vld || out_tready;
  assign in_tready = en;

  hferf_front u_front (
    .clk, .rst_n, .en,
    .in_vld (in_tvalid),
    .x_bits (in_tdata),
    .last_in(in_tlast),
    .side_o (f_side),
    .t_o    (t_lane),
    .e_o    (e_lane)
  );

  hferf_div u_div (
    .clk, .rst_n, .en,
    .side_i(f_side),
    .t_i   (t_lane),
    .e_i   (e_lane),
    .side_o(d_side),
    .t_q   (t_q),
    .e_q   (e_q)
  );

  hferf_poly u_poly (
    .clk, .rst_n, .en,
    .side_i(d_side),
    .t_i   (t_q),
    .e_i   (e_q),
    .side_o(p_side),
    .r_o   (r)
  );

  hferf_pack u_pack (
    .clk, .rst_n, .en,
    .side_i(p_side),
    .r_i   (r),
    .side_o(y_side),
    .y_o   (y)
  );

  assign out_tvalid = y_side.vld;
  assign out_tdata  = y;
  assign out_tlast  = y_side.last;

endmodule

@@ src/hferf_check.sv @@
// Port-level checks for the half-float erf pipeline, bound to the top level.
// Depends on half_float_erf_approximation only through its ports.
module hferf_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // the pipeline only stops when a result is waiting
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with a free output");

  // erf magnitude never exceeds one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:0] <= 15'h3C00)
    else $error("result magnitude above one");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("valid result right after reset");

endmodule

bind half_float_erf_approximation hferf_check u_hferf_check (.*);

@@ sim/half_float_erf_approximation_tb.sv @@
// Self-checking testbench for the half-float erf pipeline: directed table, then random
// stream with random stalls on both sides. Depends on hferf_pkg and half_float_erf_approximation.
module half_float_erf_approximation_tb;
  import hferf_pkg::*;

  localparam int LATENCY = FRAC_BITS + 18;
  localparam int N_RAND  = 1430;

  typedef struct {
    logic [15:0] x;
    logic        last;
    logic        fixed;  // expected value typed in below
    logic [15:0] y;
  } stim_row_t;

  typedef struct {
    logic [15:0] y;
    logic        last;
  } erf_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  erf_res_t erf_expected[$];
  int       n_errors = 0;
  bit       hold_off = 1'b0;   // long receiver stall window
  bit       stim_done = 1'b0;

  half_float_erf_approximation dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b) >> FRAC_BITS;
  endfunction

  function automatic logic [63:0] qsub_sat(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  function automatic logic [63:0] qdiv(logic [63:0] n, logic [63:0] d);
    return ((n << FRAC_BITS) + d / 2) / d;
  endfunction

  // fixed-point magnitude to binary16, round to nearest even
  function automatic logic [15:0] fix_to_half(logic [63:0] m);
    int msb;
    int s;
    int ex;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] halfway;
    msb = 0;
    while (msb < 63 && (m >> (msb + 1)) != 0) msb++;
    ex = msb - FRAC_BITS;
    if (ex < -14) return 16'(m << (24 - FRAC_BITS));
    if (msb > 10) begin
      s = msb - 10;
      rem = m & ((64'd1 << s) - 1);
      halfway = 64'd1 << (s - 1);
      mant = m >> s;
      if (rem > halfway || (rem == halfway && mant[0])) mant++;
    end else begin
      mant = m << (10 - msb);
    end
    return 16'((64'(ex + 15) << 10) + mant - 64'd1024);
  endfunction

  function automatic logic [15:0] erf_half(logic [15:0] x);
    logic sgn;
    logic [4:0] ex;
    logic neg;
    int sh;
    logic [63:0] m11, a, t, t2, t3, t4, t5, pos, ng, poly, u, u2, num, den, eq, prod, r;
    logic [15:0] y;
    sgn = x[15];
    ex = x[14:10];
    neg = sgn && (x[14:0] != 0);
    if (ex >= EXP_BIG) return sgn ? (HALF_ONE | HALF_SIGN) : HALF_ONE;
    m11 = (ex != 0) ? 64'(1024 + x[9:0]) : 64'(x[9:0]);
    sh = ((ex != 0) ? int'(ex) : 1) - 25 + FRAC_BITS;
    a = (sh >= 0) ? (m11 << sh) : (m11 >> (-sh));
    if (a > 4 * 64'(ONE_Q)) a = 4 * 64'(ONE_Q);
    t = qdiv(64'(ONE_Q), 64'(ONE_Q) + qmul(64'(QC_3280), a));
    t2 = qmul(t, t);
    t3 = qmul(t2, t);
    t4 = qmul(t3, t);
    t5 = qmul(t4, t);
    pos = qmul(64'(QC_2505), t) + qmul(64'(QC_14102), t3) + qmul(64'(QC_10547), t5);
    ng = qmul(64'(QC_2881), t2) + qmul(64'(QC_14230), t4);
    poly = qsub_sat(pos, ng);
    u = qmul(a, a);
    if (u > 6 * 64'(ONE_Q)) u = 6 * 64'(ONE_Q);
    u2 = qmul(u, u);
    num = qsub_sat(64'(QC_13300) + qmul(64'(QC_288), u2), qmul(64'(QC_3900), u));
    den = 64'(QC_13380) + qmul(64'(QC_8480), u) + qmul(64'(QC_4670), u2);
    eq = qdiv(num, den);
    prod = qmul(poly, eq);
    if (prod > 64'(ONE_Q)) begin
      r = prod - 64'(ONE_Q);
      neg = ~neg;
      if (r > 64'(ONE_Q)) r = 64'(ONE_Q);
    end else begin
      r = 64'(ONE_Q) - prod;
    end
    y = (r != 0) ? fix_to_half(r) : 16'h0000;
    if (neg) y = y | HALF_SIGN;
    return y;
  endfunction

  // random gap: mostly none or short, sometimes long
  function automatic int rand_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // one input transfer; the predictor queues the result on acceptance
  task automatic send_x(logic [15:0] x, logic last, logic fixed, logic [15:0] y);
    erf_res_t res;
    in_tvalid <= 1'b1;
    in_tdata <= x;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res.y = fixed ? y : erf_half(x);
    res.last = last;
    if (fixed && y !== erf_half(x))
      $display("%0t: table row %h disagrees with predictor", $time, x);
    erf_expected.push_back(res);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stimulus
  initial begin
    stim_row_t rows[$];
    logic [15:0] x;
    int p;
    rows = '{
      '{16'h0000, 1'b0, 1'b0, 16'h0000},   // +0
      '{16'h8000, 1'b0, 1'b0, 16'h0000},   // -0 takes positive path
      '{16'h0001, 1'b0, 1'b0, 16'h0000},   // smallest subnormal
      '{16'h8001, 1'b0, 1'b0, 16'h0000},
      '{16'h03FF, 1'b0, 1'b0, 16'h0000},   // largest subnormal
      '{16'h0400, 1'b0, 1'b0, 16'h0000},   // smallest normal
      '{16'h3800, 1'b0, 1'b0, 16'h0000},   // 0.5
      '{16'h3C00, 1'b0, 1'b0, 16'h0000},   // 1
      '{16'hBC00, 1'b0, 1'b0, 16'h0000},
      '{16'h4000, 1'b0, 1'b0, 16'h0000},   // 2
      '{16'h43FF, 1'b0, 1'b0, 16'h0000},   // just under 4
      '{16'hC3FF, 1'b0, 1'b0, 16'h0000},
      '{16'h4400, 1'b0, 1'b1, 16'h3C00},   // 4: large magnitude
      '{16'hC400, 1'b0, 1'b1, 16'hBC00},
      '{16'h7BFF, 1'b0, 1'b1, 16'h3C00},   // max finite
      '{16'h7C00, 1'b0, 1'b1, 16'h3C00},   // +inf
      '{16'hFC00, 1'b0, 1'b1, 16'hBC00},   // -inf
      '{16'h7E00, 1'b0, 1'b1, 16'h3C00},   // NaN by its sign bit
      '{16'hFFFF, 1'b1, 1'b1, 16'hBC00},
      '{16'h2E66, 1'b1, 1'b0, 16'h0000},   // small value, near 0.1
      '{16'h1000, 1'b0, 1'b0, 16'h0000}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      send_x(rows[i].x, rows[i].last, rows[i].fixed, rows[i].y);
      if (i % 4 == 3) idle_cycles(rand_gap());
    end
    // pause until the pipe drains
    in_tvalid <= 1'b0;
    while (erf_expected.size() != 0) @(posedge clk);
    for (int n = 0; n < N_RAND; n++) begin
      if (n == 300) hold_off = 1'b1;
      if (n == 900) begin
        in_tvalid <= 1'b0;
        while (erf_expected.size() != 0) @(posedge clk);
      end
      p = $urandom_range(99);
      if (p < 50) x = 16'($urandom_range(16'h43FF));                   // inside |x| < 4
      else if (p < 70) x = 16'($urandom_range(16'h43FF)) | HALF_SIGN;
      else if (p < 80) x = {1'($urandom_range(1)), 5'd0, 10'($urandom)}; // subnormals
      else x = 16'($urandom);
      send_x(x, 1'($urandom_range(1)), 1'b0, 16'h0000);
      if (n % 7 == 0 || $urandom_range(3) == 0) idle_cycles(rand_gap());
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random readiness, one long stall
  initial begin
    int g;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_tready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk);
      end
      g = rand_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    erf_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (erf_expected.size() == 0) begin
        $display("%0t: unexpected result y=%h last=%b", $time, out_tdata, out_tlast);
        n_errors++;
      end else begin
        e = erf_expected.pop_front();
        if (out_tdata !== e.y) begin
          $display("%0t: y_bits expected %h actual %h", $time, e.y, out_tdata);
          n_errors++;
        end
        if (out_tlast !== e.last) begin
          $display("%0t: last expected %b actual %b", $time, e.last, out_tlast);
          n_errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (erf_expected.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (n_errors == 0 && erf_expected.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
